FILE: rtl/core/aes_ctr_pkg.sv
// ----------------------------------------------------------------------------
// AES-256 CTR package
// Shared widths, register indexes, S-box and round helper functions.
// ----------------------------------------------------------------------------
package aes_ctr_pkg;

  localparam int unsigned WordW    = 64;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned BlockW   = 128;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegKey0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey1   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey2   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey3   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCtrHi  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCtrLo  = 3'd5;

  typedef struct packed {
    logic [WordW-1:0] data_high;
    logic [WordW-1:0] data_low;
    logic             final_block;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] out_high;
    logic [WordW-1:0] out_low;
    logic             out_final;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [WordW-1:0]   value;
  } cfg_item_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] r;
    case (x)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // One cipher round without the key addition; byte 0 is the top byte
  function automatic logic [BlockW-1:0] round_fn(input logic [BlockW-1:0] s,
                                                 input logic last);
    logic [7:0] sb [16];
    logic [7:0] t [16];
    logic [7:0] o [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [BlockW-1:0] res;
    for (int i = 0; i < 16; i++) sb[i] = sbox(s[BlockW-1-8*i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[c*4+i] = sb[((c+i) % 4)*4+i];
    for (int c = 0; c < 4; c++) begin
      a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      o[c*4]   = last ? a0 : a0 ^ all ^ xtime(a0 ^ a1);
      o[c*4+1] = last ? a1 : a1 ^ all ^ xtime(a1 ^ a2);
      o[c*4+2] = last ? a2 : a2 ^ all ^ xtime(a2 ^ a3);
      o[c*4+3] = last ? a3 : a3 ^ all ^ xtime(a3 ^ a0);
    end
    for (int i = 0; i < 16; i++) res[BlockW-1-8*i -: 8] = o[i];
    return res;
  endfunction

endpackage

FILE: rtl/core/aes_ctr_if.sv
// ----------------------------------------------------------------------------
// AES-256 CTR channel interfaces
// Valid/ready channels for data items, results and register writes.
// ----------------------------------------------------------------------------
interface aes_ctr_in_if;
  logic                 valid;
  logic                 ready;
  aes_ctr_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface aes_ctr_out_if;
  logic                  valid;
  logic                  ready;
  aes_ctr_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface aes_ctr_cfg_if;
  logic                  valid;
  logic                  ready;
  aes_ctr_pkg::cfg_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/aes256_ctr_cipher_unit.sv
// ----------------------------------------------------------------------------
// AES-256 CTR cipher unit
// Counter-mode AES-256 with round keys held in a synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i  : register writes (index, 64-bit value). Indexes 0..3 hold the key,
//            4 and 5 load the upper and lower counter halves. A key write
//            starts an expansion into the round key memory; the write channel
//            and the data channel stall until it is done.
//   in_i   : one 128-bit block per item plus the last-block mark. An item
//            offered together with a register write waits for the write.
//   out_o  : data XOR keystream, with the mark copied through.
// Pacing: one item at a time, set by the single 64-bit port of the
//   round key memory: the key addition and 14 rounds need 30 words, read one
//   per cycle, after the idle state that takes the item. The next item is
//   taken while a result waits.
// Reset: the all-zero key is expanded (no item taken) and the counter
//   clears. The running counter advances by one per item, with full 128-bit
//   carry, wrapping at all ones.
// Stall: a result held in the output register keeps the following item in
//   its last round until the receiver takes it; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module aes256_ctr_cipher_unit #(
  parameter int unsigned ROUND_COUNT = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  aes_ctr_cfg_if.sink   cfg_i,
  aes_ctr_in_if.sink    in_i,
  aes_ctr_out_if.source out_o
);

  localparam int unsigned KeyWords32 = 4 * (ROUND_COUNT + 1);
  localparam int unsigned StoreWords = 2 * (ROUND_COUNT + 1);
  localparam int unsigned AddrW      = $clog2(StoreWords);
  localparam int unsigned ExpW       = $clog2(KeyWords32 + 1);
  localparam int unsigned RndW       = $clog2(ROUND_COUNT + 1);

  typedef enum logic [2:0] {
    ST_EXPAND, ST_IDLE, ST_LOAD_HI, ST_LOAD_LO, ST_RUN, ST_DONE
  } state_e;

  state_e            state_q;
  logic [63:0]       key_q [4];
  logic [127:0]      ctr_q;
  logic [127:0]      st_q;
  logic [127:0]      data_q;
  logic              fin_q;
  logic [RndW-1:0]   rnd_q;
  logic [63:0]       rk_hi_q;
  // Expansion: sliding window of the last eight 32-bit words
  logic [31:0]       win_q [8];
  logic [ExpW-1:0]   exp_q;
  logic [31:0]       pend_q;
  logic [2:0]        rcon_q;

  // Round key memory
  logic [63:0]       rk_mem [StoreWords];
  logic [63:0]       rd_q;
  logic [AddrW-1:0]  rd_addr;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [63:0]       wr_data;

  logic [31:0]       exp_t;
  logic [31:0]       exp_new;
  logic [127:0]      rk_full;
  logic [127:0]      rnd_out;
  logic              cfg_fire;
  logic              in_fire;
  logic              out_load;
  logic [7:0]        rcon_b;

  function automatic logic [31:0] sub_word_rot(input logic [31:0] w);
    return aes_ctr_pkg::sub_word({w[23:0], w[31:24]});
  endfunction

  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_i.ready = (state_q == ST_IDLE);
  // A register write goes first; hold the data item back meanwhile
  assign in_i.ready  = (state_q == ST_IDLE) && !cfg_i.valid;

  // Round constant for this expansion step
  always_comb begin
    case (rcon_q)
      3'd0: rcon_b = 8'h01;
      3'd1: rcon_b = 8'h02;
      3'd2: rcon_b = 8'h04;
      3'd3: rcon_b = 8'h08;
      3'd4: rcon_b = 8'h10;
      3'd5: rcon_b = 8'h20;
      3'd6: rcon_b = 8'h40;
      default: rcon_b = 8'h00;
    endcase
  end

  // Next expanded word from the window
  always_comb begin
    exp_t = win_q[7];
    if (exp_q[2:0] == 3'd0) begin
      exp_t = sub_word_rot(win_q[7]) ^ {rcon_b, 24'h0};
    end else if (exp_q[2:0] == 3'd4) begin
      exp_t = aes_ctr_pkg::sub_word(win_q[7]);
    end
    exp_new = win_q[0] ^ exp_t;
  end

  // Write port: one 32-bit word per cycle, paired into 64-bit entries
  always_comb begin
    wr_en   = (state_q == ST_EXPAND) && exp_q[0];
    wr_addr = AddrW'((exp_q >> 1));
    wr_data = (exp_q < ExpW'(8)) ? {pend_q, win_q[exp_q[2:0]]} : {pend_q, exp_new};
  end

  // Read address: key word for the next cycle of the round sequence
  always_comb begin
    case (state_q)
      ST_IDLE:    rd_addr = '0;
      ST_LOAD_HI: rd_addr = AddrW'(1);
      ST_LOAD_LO: rd_addr = AddrW'(2);
      ST_RUN:     rd_addr = AddrW'(2 * rnd_q + 1);
      // keep the last word on the read port while the result waits
      ST_DONE:    rd_addr = (rnd_q == RndW'(ROUND_COUNT)) ? AddrW'(2 * rnd_q + 1)
                                                          : AddrW'(2 * rnd_q + 2);
      default:    rd_addr = '0;
    endcase
  end

  assign rk_full  = {rk_hi_q, rd_q};
  assign rnd_out  = aes_ctr_pkg::round_fn(st_q, rnd_q == RndW'(ROUND_COUNT));
  assign out_load = (state_q == ST_DONE) && (rnd_q == RndW'(ROUND_COUNT)) &&
                    (!out_o.valid || out_o.ready);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rk_mem[wr_addr] <= wr_data;
    end
    rd_q <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EXPAND;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      for (int i = 0; i < 8; i++) win_q[i] <= '0;
      ctr_q   <= '0;
      exp_q   <= '0;
      rcon_q  <= '0;
      rnd_q   <= '0;
      out_o.valid <= 1'b0;
    end else begin
      // Raise on a new result, drop once the receiver takes it
      if (out_load) begin
        out_o.valid <= 1'b1;
      end else if (out_o.ready) begin
        out_o.valid <= 1'b0;
      end
      case (state_q)
        ST_EXPAND: begin
          // First eight words come straight from the key, then slide
          if (exp_q < ExpW'(8)) begin
            if (!exp_q[0]) pend_q <= win_q[exp_q[2:0]];
          end else begin
            if (!exp_q[0]) pend_q <= exp_new;
            for (int i = 0; i < 7; i++) win_q[i] <= win_q[i+1];
            win_q[7] <= exp_new;
            if (exp_q[2:0] == 3'd0) rcon_q <= rcon_q + 3'd1;
          end
          if (exp_q == ExpW'(7)) begin
            // window now holds key words; start generating
            exp_q <= exp_q + ExpW'(1);
          end else if (exp_q == ExpW'(KeyWords32 - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            exp_q <= exp_q + ExpW'(1);
          end
        end
        ST_IDLE: begin
          if (cfg_fire) begin
            case (cfg_i.payload.index)
              aes_ctr_pkg::RegKey0, aes_ctr_pkg::RegKey1,
              aes_ctr_pkg::RegKey2, aes_ctr_pkg::RegKey3: begin
                key_q[cfg_i.payload.index[1:0]] <= cfg_i.payload.value;
                for (int i = 0; i < 4; i++) begin
                  if (cfg_i.payload.index[1:0] == 2'(i)) begin
                    win_q[2*i]   <= cfg_i.payload.value[63:32];
                    win_q[2*i+1] <= cfg_i.payload.value[31:0];
                  end else begin
                    win_q[2*i]   <= key_q[i][63:32];
                    win_q[2*i+1] <= key_q[i][31:0];
                  end
                end
                exp_q   <= '0;
                rcon_q  <= '0;
                state_q <= ST_EXPAND;
              end
              aes_ctr_pkg::RegCtrHi: ctr_q[127:64] <= cfg_i.payload.value;
              aes_ctr_pkg::RegCtrLo: ctr_q[63:0]   <= cfg_i.payload.value;
              default: ;
            endcase
          end else if (in_fire) begin
            data_q  <= {in_i.payload.data_high, in_i.payload.data_low};
            fin_q   <= in_i.payload.final_block;
            st_q    <= ctr_q;
            ctr_q   <= ctr_q + 128'd1;
            state_q <= ST_LOAD_HI;
          end
        end
        ST_LOAD_HI: begin
          // word 0 of round key 0 arrives now
          rk_hi_q <= rd_q;
          rnd_q   <= '0;
          state_q <= ST_LOAD_LO;
        end
        ST_LOAD_LO: begin
          // initial key addition; fetch round 1 high word
          st_q    <= st_q ^ rk_full;
          rnd_q   <= RndW'(1);
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          // latch the high word of this round's key
          rk_hi_q <= rd_q;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // apply the round with both key halves present
          if (rnd_q == RndW'(ROUND_COUNT)) begin
            if (out_load) begin
              out_o.payload.out_high  <= data_q[127:64] ^ (rnd_out[127:64] ^ rk_full[127:64]);
              out_o.payload.out_low   <= data_q[63:0] ^ (rnd_out[63:0] ^ rk_full[63:0]);
              out_o.payload.out_final <= fin_q;
              state_q                 <= ST_IDLE;
            end
          end else begin
            st_q    <= rnd_out ^ rk_full;
            rnd_q   <= rnd_q + RndW'(1);
            state_q <= ST_RUN;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/aes256_ctr_checker.sv
// ----------------------------------------------------------------------------
// AES-256 CTR result checker
// Watches the register, data and result channels, keeps its own key schedule
// and running counter, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module aes256_ctr_checker
  import aes_ctr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  cfg_item_t   cfg_payload_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_payload_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_payload_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned Rounds = 14;

  logic [7:0] sbox_lut [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  logic [63:0]  key_regs [4];
  logic [127:0] round_keys [Rounds+1];
  logic [127:0] counter_q;
  out_item_t    expected_q [$];

  function automatic logic [31:0] subst32(input logic [31:0] w);
    return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
  endfunction

  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Rebuild the key schedule from the four key words as they stand
  task automatic build_schedule();
    logic [31:0] w [4*(Rounds+1)];
    logic [31:0] t;
    logic [7:0]  rc;
    for (int i = 0; i < 8; i++) w[i] = i[0] ? key_regs[i/2][31:0] : key_regs[i/2][63:32];
    rc = 8'h01;
    for (int i = 8; i < 4*(Rounds+1); i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        t = subst32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = dbl(rc);
      end else if (i % 8 == 4) begin
        t = subst32(t);
      end
      w[i] = w[i-8] ^ t;
    end
    for (int r = 0; r <= Rounds; r++) round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  // Encrypt one counter block; byte 0 is the top byte
  function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] all;
    logic [127:0] st;
    st = blk ^ round_keys[0];
    for (int r = 1; r <= Rounds; r++) begin
      for (int i = 0; i < 16; i++) s[i] = sbox_lut[st[127-8*i -: 8]];
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[c*4+i] = s[((c+i)%4)*4+i];
      for (int c = 0; c < 4; c++) begin
        all = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
        for (int i = 0; i < 4; i++)
          s[c*4+i] = (r == Rounds) ? t[c*4+i]
                   : t[c*4+i] ^ all ^ dbl(t[c*4+i] ^ t[c*4+(i+1)%4]);
      end
      for (int i = 0; i < 16; i++) st[127-8*i -: 8] = s[i];
      st = st ^ round_keys[r];
    end
    return st;
  endfunction

  initial begin
    for (int i = 0; i < 4; i++) key_regs[i] = '0;
    counter_q = '0;
    build_schedule();
  end

  assign pending_o = expected_q.size();

  // Track writes, predict on each item, compare on each result
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    logic [127:0] ks;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_payload_i.index)
          RegKey0, RegKey1, RegKey2, RegKey3: begin
            key_regs[cfg_payload_i.index[1:0]] = cfg_payload_i.value;
            build_schedule();
          end
          RegCtrHi: counter_q[127:64] = cfg_payload_i.value;
          RegCtrLo: counter_q[63:0] = cfg_payload_i.value;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        ks = encrypt_block(counter_q);
        exp_item.out_high  = in_payload_i.data_high ^ ks[127:64];
        exp_item.out_low   = in_payload_i.data_low ^ ks[63:0];
        exp_item.out_final = in_payload_i.final_block;
        expected_q.push_back(exp_item);
        counter_q = counter_q + 128'd1;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_payload_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_item = expected_q.pop_front();
          if (exp_item.out_high !== out_payload_i.out_high ||
              exp_item.out_low !== out_payload_i.out_low ||
              exp_item.out_final !== out_payload_i.out_final) begin
            $display("%0t: mismatch expected %h/%h/%b actual %h/%h/%b", $time,
                     exp_item.out_high, exp_item.out_low, exp_item.out_final,
                     out_payload_i.out_high, out_payload_i.out_low,
                     out_payload_i.out_final);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb_aes256_ctr_cipher_unit.sv
// ----------------------------------------------------------------------------
// AES-256 CTR cipher unit testbench
// Drives register writes and data blocks under varied idling, and takes the
// verdict from the checker that predicts every result.
// ----------------------------------------------------------------------------
module tb_aes256_ctr_cipher_unit;
  import aes_ctr_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  logic clk_i;
  logic rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic [2:0] idx_all [7];

  aes_ctr_cfg_if cfg_ch ();
  aes_ctr_in_if  in_ch ();
  aes_ctr_out_if out_ch ();

  aes256_ctr_cipher_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch.sink),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  aes256_ctr_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_ch.valid),
    .cfg_ready_i   (cfg_ch.ready),
    .cfg_payload_i (cfg_ch.payload),
    .in_valid_i    (in_ch.valid),
    .in_ready_i    (in_ch.ready),
    .in_payload_i  (in_ch.payload),
    .out_valid_i   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .out_payload_i (out_ch.payload),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Stall the result side at the phase's rate
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Count cycles with nothing accepted
  always @(posedge clk_i) begin
    if ((cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Write one register; valid stays up until the next call drops or reuses it
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    in_ch.valid          <= 1'b0;
    cfg_ch.valid         <= 1'b1;
    cfg_ch.payload.index <= idx;
    cfg_ch.payload.value <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // Send one block, with random idle cycles ahead of it
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                            input logic fin);
    cfg_ch.valid <= 1'b0;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid               <= 1'b1;
    in_ch.payload.data_high   <= hi;
    in_ch.payload.data_low    <= lo;
    in_ch.payload.final_block <= fin;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Hold until every result is back, then let the block settle
  task automatic drain();
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    idx_all = '{RegKey0, RegKey1, RegKey2, RegKey3, RegCtrHi, RegCtrLo, 3'd7};
    rst_ni = 1'b0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: all-zero key, field extremes, counter wrap
    send_block('0, '0, 1'b0);
    send_block('1, '1, 1'b1);
    send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0);
    drain();
    write_reg(RegCtrHi, '1);
    write_reg(RegCtrLo, 64'hffff_ffff_ffff_fffe);
    repeat (4) send_block(rand64(), rand64(), 1'b0);
    drain();
    // Carry across the low half only
    write_reg(RegCtrHi, 64'h0123_4567_89ab_cdef);
    write_reg(RegCtrLo, '1);
    repeat (2) send_block(rand64(), rand64(), 1'b1);
    drain();
    // All-ones key, then the FIPS-197 key, each word written on its own
    for (int i = 0; i < 4; i++) write_reg(idx_all[i], '1);
    send_block('0, '0, 1'b0);
    drain();
    write_reg(RegKey0, 64'h0001_0203_0405_0607);
    send_block('0, '0, 1'b0);
    drain();
    write_reg(RegKey1, 64'h0809_0a0b_0c0d_0e0f);
    write_reg(RegKey2, 64'h1011_1213_1415_1617);
    write_reg(RegKey3, 64'h1819_1a1b_1c1d_1e1f);
    write_reg(RegCtrHi, 64'h0011_2233_4455_6677);
    write_reg(RegCtrLo, 64'h8899_aabb_ccdd_eeff);
    send_block('0, '0, 1'b1);
    drain();
    // Unknown index changes nothing; low-half write keeps the high half
    write_reg(3'd6, '1);
    write_reg(3'd7, '1);
    write_reg(RegCtrLo, '0);
    send_block(rand64(), rand64(), 1'b0);
    drain();

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int k = 0; k < 3; k++) write_reg(idx_all[$urandom_range(6)], rand64());
      if ($urandom_range(3) == 0) begin
        write_reg(RegCtrHi, rand64());
        write_reg(RegCtrLo, 64'hffff_ffff_ffff_fff0 | 64'($urandom_range(15)));
      end
      repeat (60) send_block(rand64(), rand64(), 1'($urandom_range(1)));
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/aes_ctr_pkg.sv
rtl/core/aes_ctr_if.sv
rtl/core/aes256_ctr_cipher_unit.sv
tb/aes256_ctr_checker.sv
tb/tb_aes256_ctr_cipher_unit.sv
